[hw/rtl/tst_pkg.sv]
`timescale 1ns / 1ps

package tst_pkg;

  localparam int CP_W  = 21;
  localparam int CAP_W = 13;
  localparam int ST_W  = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

  localparam logic [ST_W-1:0] ST_PENDING = 2'd0;
  localparam logic [ST_W-1:0] ST_PRESENT = 2'd1;
  localparam logic [ST_W-1:0] ST_ABSENT  = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd3;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_LOW   = 2'd1,
    KIND_EQUAL = 2'd2,
    KIND_HIGH  = 2'd3
  } tst_kind_t;

  typedef struct packed {
    logic skip;
    logic absent;
    logic lookup;
    logic no_room;
    logic char_eq;
    logic char_gt;
  } tst_stat_t;

  typedef struct packed {
    logic load;
    logic alloc;
    logic hit;
    logic go_low;
    logic go_high;
    logic link;
    logic miss;
    logic full;
    logic done;
  } tst_cmd_t;

endpackage

[hw/rtl/tst_ctrl.sv]
`timescale 1ns / 1ps

module tst_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  tst_pkg::tst_stat_t stat,
  output tst_pkg::tst_cmd_t  cmd,
  output logic               busy
);
  import tst_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_CMP   = 4'b0100,
    S_LINK  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (stat.skip) begin
          cmd.done  = 1'b1;
          state_nxt = S_IDLE;
        end else if (stat.absent && stat.lookup) begin
          cmd.miss  = 1'b1;
          cmd.done  = 1'b1;
          state_nxt = S_IDLE;
        end else if (stat.absent && stat.no_room) begin
          cmd.full  = 1'b1;
          cmd.done  = 1'b1;
          state_nxt = S_IDLE;
        end else if (stat.absent) begin
          cmd.alloc = 1'b1;
          state_nxt = S_LINK;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        priority if (stat.char_eq) begin
          cmd.hit   = 1'b1;
          cmd.done  = 1'b1;
          state_nxt = S_IDLE;
        end else if (stat.char_gt) begin
          cmd.go_low = 1'b1;
          state_nxt  = S_CHECK;
        end else begin
          cmd.go_high = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_LINK: begin
        cmd.link  = 1'b1;
        cmd.done  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

[hw/rtl/tst_dp.sv]
`timescale 1ns / 1ps

module tst_dp #(
  parameter  int NODES = 4096,
  localparam int IW    = $clog2(NODES + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_mode,
  input  logic [tst_pkg::CP_W-1:0]  in_code_point,
  input  logic                      in_last_char,
  input  logic                      cfg_wr_en,
  input  logic [tst_pkg::CAP_W-1:0] cfg_wr_data,
  input  tst_pkg::tst_cmd_t         cmd,
  output tst_pkg::tst_stat_t        stat,
  output logic                      out_valid,
  output logic [tst_pkg::ST_W-1:0]  out_status,
  output logic [IW-1:0]             out_node_index,
  output logic                      out_word_done
);
  import tst_pkg::*;

  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int CW = (IW > CAP_W) ? IW : CAP_W;
  localparam logic [IW-1:0] NONE_IDX = IW'(NODES);

  logic [CP_W-1:0] node_char  [NODES];
  logic            node_end   [NODES];
  logic [IW-1:0]   node_low   [NODES];
  logic [IW-1:0]   node_equal [NODES];
  logic [IW-1:0]   node_high  [NODES];

  logic            mode_r, last_r;
  logic [CP_W-1:0] cp_r;
  logic [IW-1:0]   idx_r, cursor_r, patch_node_r, used_r;
  tst_kind_t       patch_kind_r;
  logic            flag_new_r, flag_full_r, flag_miss_r;
  logic [CAP_W-1:0] cap_r;
  logic            out_valid_r, out_word_done_r;
  logic [ST_W-1:0] out_status_r;
  logic [IW-1:0]   out_node_index_r;

  logic [CP_W-1:0] char_rd;
  logic            end_rd;
  logic [IW-1:0]   low_rd, equal_rd, high_rd;

  logic [AW-1:0]   rd_addr, new_addr, patch_addr;
  logic            end_we, low_we, equal_we, high_we;
  logic [AW-1:0]   end_wa, low_wa, equal_wa, high_wa;
  logic [IW-1:0]   low_wd, equal_wd, high_wd;
  logic            ins_last;

  logic            full_now, miss_now, hit_now;
  logic [ST_W-1:0] status_nxt;
  logic [IW-1:0]   nidx_nxt;

  assign rd_addr    = idx_r[AW-1:0];
  assign new_addr   = used_r[AW-1:0];
  assign patch_addr = patch_node_r[AW-1:0];
  assign ins_last   = last_r && (mode_r == MODE_INSERT);

  // status toward the controller
  assign stat.skip    = flag_full_r || ((mode_r == MODE_LOOKUP) && flag_miss_r);
  assign stat.absent  = (idx_r >= used_r);
  assign stat.lookup  = (mode_r == MODE_LOOKUP);
  assign stat.no_room = (CW'(used_r) >= CW'(cap_r)) || (used_r >= NONE_IDX);
  assign stat.char_eq = (char_rd == cp_r);
  assign stat.char_gt = (char_rd > cp_r);

  // node store write ports
  always_comb begin
    end_we   = cmd.alloc || (cmd.hit && ins_last);
    end_wa   = cmd.alloc ? new_addr : rd_addr;
    low_we   = cmd.alloc || (cmd.link && (patch_kind_r == KIND_LOW));
    low_wa   = cmd.alloc ? new_addr : patch_addr;
    low_wd   = cmd.alloc ? NONE_IDX : idx_r;
    equal_we = cmd.alloc || (cmd.link && (patch_kind_r == KIND_EQUAL));
    equal_wa = cmd.alloc ? new_addr : patch_addr;
    equal_wd = cmd.alloc ? NONE_IDX : idx_r;
    high_we  = cmd.alloc || (cmd.link && (patch_kind_r == KIND_HIGH));
    high_wa  = cmd.alloc ? new_addr : patch_addr;
    high_wd  = cmd.alloc ? NONE_IDX : idx_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc) begin
      node_char[new_addr] <= cp_r;
    end
    char_rd <= node_char[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (end_we) begin
      node_end[end_wa] <= ins_last;
    end
    end_rd <= node_end[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (low_we) begin
      node_low[low_wa] <= low_wd;
    end
    low_rd <= node_low[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (equal_we) begin
      node_equal[equal_wa] <= equal_wd;
    end
    equal_rd <= node_equal[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (high_we) begin
      node_high[high_wa] <= high_wd;
    end
    high_rd <= node_high[rd_addr];
  end

  // result of the current word
  always_comb begin
    full_now = flag_full_r || cmd.full;
    miss_now = flag_miss_r || cmd.miss;
    hit_now  = cmd.hit || cmd.link;
    nidx_nxt = hit_now ? idx_r : NONE_IDX;
    if (full_now) begin
      status_nxt = ST_FULL;
      nidx_nxt   = NONE_IDX;
    end else if (!last_r) begin
      status_nxt = ST_PENDING;
    end else if (mode_r == MODE_INSERT) begin
      status_nxt = flag_new_r ? ST_ABSENT : ST_PRESENT;
    end else if (miss_now || !hit_now) begin
      status_nxt = ST_ABSENT;
    end else begin
      status_nxt = end_rd ? ST_PRESENT : ST_ABSENT;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      cp_r   <= in_code_point;
      last_r <= in_last_char;
    end
    if (cmd.done) begin
      out_status_r     <= status_nxt;
      out_node_index_r <= nidx_nxt;
      out_word_done_r  <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r        <= '0;
      cursor_r     <= '0;
      patch_node_r <= NONE_IDX;
      patch_kind_r <= KIND_NONE;
      used_r       <= '0;
      flag_new_r   <= 1'b0;
      flag_full_r  <= 1'b0;
      flag_miss_r  <= 1'b0;
      cap_r        <= CAP_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= cmd.done;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (cmd.load) begin
        idx_r <= cursor_r;
      end
      if (cmd.alloc) begin
        idx_r      <= used_r;
        used_r     <= used_r + IW'(1);
        flag_new_r <= 1'b1;
      end
      if (cmd.go_low) begin
        patch_node_r <= idx_r;
        patch_kind_r <= KIND_LOW;
        idx_r        <= low_rd;
      end
      if (cmd.go_high) begin
        patch_node_r <= idx_r;
        patch_kind_r <= KIND_HIGH;
        idx_r        <= high_rd;
      end
      // word end restarts the walk at the root
      if (cmd.done && last_r) begin
        cursor_r     <= '0;
        patch_node_r <= NONE_IDX;
        patch_kind_r <= KIND_NONE;
        flag_new_r   <= 1'b0;
        flag_full_r  <= 1'b0;
        flag_miss_r  <= 1'b0;
      end else begin
        if (cmd.hit) begin
          patch_node_r <= idx_r;
          patch_kind_r <= KIND_EQUAL;
          cursor_r     <= equal_rd;
        end
        if (cmd.link) begin
          patch_node_r <= idx_r;
          patch_kind_r <= KIND_EQUAL;
          cursor_r     <= NONE_IDX;
        end
        if (cmd.miss) begin
          flag_miss_r <= 1'b1;
          cursor_r    <= NONE_IDX;
        end
        if (cmd.full) begin
          flag_full_r <= 1'b1;
          cursor_r    <= NONE_IDX;
        end
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_node_index = out_node_index_r;
  assign out_word_done  = out_word_done_r;

endmodule

[hw/rtl/ternary_search_tree_insert_lookup_top.sv]
// walk: a word that is skipped, misses or finds the store full ends in the check state, a
//   match in the compare state and a new node in the link state after its allocation
// handshake: the next word is accepted in the out_valid cycle; each low or high sibling
//   link walked takes one registered node read and one compare
// reset: synchronous active-low rst_n clears the walk and node count, capacity 4096
// out_valid is a one-cycle strobe; the receiver cannot stall
`timescale 1ns / 1ps

module ternary_search_tree_insert_lookup_top #(
  parameter  int NODES = 4096,
  localparam int IW    = $clog2(NODES + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_mode,
  input  logic [tst_pkg::CP_W-1:0]  in_code_point,
  input  logic                      in_last_char,
  output logic                      out_valid,
  output logic [tst_pkg::ST_W-1:0]  out_status,
  output logic [IW-1:0]             out_node_index,
  output logic                      out_word_done,
  input  logic                      cfg_wr_en,
  input  logic [tst_pkg::CAP_W-1:0] cfg_wr_data
);
  import tst_pkg::*;

  tst_cmd_t  cmd;
  tst_stat_t stat;
  logic      ctrl_busy;

  tst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (ctrl_busy)
  );

  tst_dp #(
    .NODES (NODES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mode        (in_mode),
    .in_code_point  (in_code_point),
    .in_last_char   (in_last_char),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_node_index (out_node_index),
    .out_word_done  (out_word_done)
  );

  assign busy = ctrl_busy;

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe on back-to-back cycles");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while a word is in flight");

  a_full_none: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL)) |-> (out_node_index == IW'(NODES)))
    else $error("store full result carries a node index");
`endif

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import tst_pkg::*;

  localparam int NODES = 4096;
  localparam int IW = $clog2(NODES + 1);
  localparam logic [IW-1:0] NONE_IX = IW'(NODES);
  localparam int RANDOM_ITEMS = 1100;
  localparam int PHASES = 8;

  typedef enum bit {ROW_WORD, ROW_CAP} row_kind_t;

  typedef struct packed {
    logic [ST_W-1:0] status;
    logic [IW-1:0]   node_index;
    logic            word_done;
  } word_res_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [CAP_W-1:0] cap;
    logic             mode;
    logic [CP_W-1:0]  cp;
    logic             last;
    bit               typed;
    word_res_t        res;
  } dir_row_t;

  typedef struct {
    int              len;
    logic [CP_W-1:0] ch [6];
  } tst_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_mode = MODE_INSERT;
  logic [CP_W-1:0] in_code_point = '0;
  logic in_last_char = 1'b0;
  logic out_valid;
  logic [ST_W-1:0] out_status;
  logic [IW-1:0] out_node_index;
  logic out_word_done;
  logic cfg_wr_en = 1'b0;
  logic [CAP_W-1:0] cfg_wr_data = '0;

  always #5 clk = ~clk;

  ternary_search_tree_insert_lookup_top #(.NODES(NODES)) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_code_point  (in_code_point),
    .in_last_char   (in_last_char),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_node_index (out_node_index),
    .out_word_done  (out_word_done),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  // shadow tree
  logic [CP_W-1:0] tree_cp   [NODES];
  logic            tree_end  [NODES];
  logic [IW-1:0]   tree_low  [NODES];
  logic [IW-1:0]   tree_eq   [NODES];
  logic [IW-1:0]   tree_high [NODES];
  logic [IW-1:0]   nodes_used = '0;
  logic [IW-1:0]   walk_pos = '0;
  logic [IW-1:0]   link_node = NONE_IX;
  tst_kind_t       link_kind = KIND_NONE;
  bit              made_node, store_full, look_missed;
  logic [CAP_W-1:0] cap_reg = CAP_RESET;

  word_res_t word_q[$];
  tst_word_t inserted_words[$];
  int mismatches = 0;
  int burst_left = 0;

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic word_res_t tree_step(logic m, logic [CP_W-1:0] cp, logic l);
    word_res_t r;
    logic [IW-1:0] ix;
    logic [IW-1:0] eff_cap;
    bit hit;
    r.status = ST_PENDING;
    r.node_index = NONE_IX;
    r.word_done = l;
    hit = 0;
    if (!store_full && !(m == MODE_LOOKUP && look_missed)) begin
      ix = walk_pos;
      eff_cap = (cap_reg > NODES) ? NONE_IX : cap_reg;
      for (int steps = 0; steps <= NODES; steps++) begin
        if (ix >= nodes_used) begin
          if (m == MODE_LOOKUP) begin
            look_missed = 1;
            break;
          end
          if (nodes_used >= eff_cap) begin
            store_full = 1;
            break;
          end
          ix = nodes_used;
          nodes_used++;
          tree_cp[ix] = cp;
          tree_end[ix] = 1'b0;
          tree_low[ix] = NONE_IX;
          tree_eq[ix] = NONE_IX;
          tree_high[ix] = NONE_IX;
          if (link_node < nodes_used) begin
            case (link_kind)
              KIND_LOW:   tree_low[link_node] = ix;
              KIND_EQUAL: tree_eq[link_node] = ix;
              KIND_HIGH:  tree_high[link_node] = ix;
              default:    ;
            endcase
          end
          made_node = 1;
        end
        if (tree_cp[ix] == cp) begin
          if (l && m == MODE_INSERT) tree_end[ix] = 1'b1;
          r.node_index = ix;
          hit = 1;
          link_node = ix;
          link_kind = KIND_EQUAL;
          walk_pos = tree_eq[ix];
          break;
        end else if (tree_cp[ix] > cp) begin
          link_node = ix;
          link_kind = KIND_LOW;
          ix = tree_low[ix];
        end else begin
          link_node = ix;
          link_kind = KIND_HIGH;
          ix = tree_high[ix];
        end
      end
      if (!hit) walk_pos = NONE_IX;
    end
    if (store_full) begin
      r.status = ST_FULL;
      r.node_index = NONE_IX;
    end else if (l) begin
      if (m == MODE_INSERT) r.status = made_node ? ST_ABSENT : ST_PRESENT;
      else if (look_missed || !hit) r.status = ST_ABSENT;
      else r.status = tree_end[r.node_index] ? ST_PRESENT : ST_ABSENT;
    end
    if (l) begin
      walk_pos = '0;
      link_node = NONE_IX;
      link_kind = KIND_NONE;
      made_node = 0;
      store_full = 0;
      look_missed = 0;
    end
    return r;
  endfunction

  task automatic send_char(logic m, logic [CP_W-1:0] cp, logic l, bit typed, word_res_t tres);
    int gap;
    word_res_t p;
    gap = (burst_left > 0) ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= m;
    in_code_point <= cp;
    in_last_char <= l;
    do @(posedge clk); while (busy);
    p = tree_step(m, cp, l);
    word_q.insert(word_q.size(), typed ? tres : p);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (word_q.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cap(logic [CAP_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cap_reg = v;
  endtask

  function automatic dir_row_t cap_row(logic [CAP_W-1:0] v);
    dir_row_t r;
    r = '0;
    r.kind = ROW_CAP;
    r.cap = v;
    return r;
  endfunction

  function automatic dir_row_t word_row(logic m, logic [CP_W-1:0] cp, logic l,
                                        bit typed = 0, logic [ST_W-1:0] st = ST_PENDING,
                                        logic [IW-1:0] ix = NONE_IX);
    dir_row_t r;
    r.kind = ROW_WORD;
    r.cap = '0;
    r.mode = m;
    r.cp = cp;
    r.last = l;
    r.typed = typed;
    r.res.status = st;
    r.res.node_index = ix;
    r.res.word_done = l;
    return r;
  endfunction

  always @(posedge clk) begin
    word_res_t e;
    if (rst_n && out_valid) begin
      if (word_q.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        e = word_q.pop_front();
        if (out_status !== e.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_status, e.status));
        if (out_node_index !== e.node_index)
          report_mismatch($sformatf("node_index %0d, expected %0d",
                                    out_node_index, e.node_index));
        if (out_word_done !== e.word_done)
          report_mismatch($sformatf("word_done %0b, expected %0b",
                                    out_word_done, e.word_done));
      end
    end
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    dir_row_t dir_tab[$];
    logic [CP_W-1:0] edge_cps[5];
    logic [CP_W-1:0] alpha[6];
    logic [CAP_W-1:0] cap_v;
    tst_word_t w;
    word_res_t none_res;
    int sent, roll, mode_roll, target;
    bit mixed;
    logic m;

    none_res = '0;
    edge_cps = '{21'd1, 21'd1114111, 21'h0FFFFF, 21'h100000, 21'd2};
    dir_tab = {
      cap_row(CAP_RESET),
      word_row(MODE_LOOKUP, 21'd97, 1'b1, 1, ST_ABSENT, NONE_IX),
      word_row(MODE_INSERT, 21'd1, 1'b1, 1, ST_ABSENT, 13'd0),
      word_row(MODE_INSERT, 21'd1, 1'b1, 1, ST_PRESENT, 13'd0),
      word_row(MODE_LOOKUP, 21'd1, 1'b1, 1, ST_PRESENT, 13'd0),
      word_row(MODE_INSERT, 21'd1114111, 1'b0, 1, ST_PENDING, 13'd1),
      word_row(MODE_INSERT, 21'd1114111, 1'b1, 1, ST_ABSENT, 13'd2),
      word_row(MODE_LOOKUP, 21'd1114111, 1'b1, 1, ST_ABSENT, 13'd1),
      word_row(MODE_LOOKUP, 21'd1114111, 1'b0),
      word_row(MODE_LOOKUP, 21'd1114111, 1'b1),
      word_row(MODE_INSERT, 21'd0, 1'b1),
      word_row(MODE_LOOKUP, 21'd0, 1'b1),
      word_row(MODE_LOOKUP, 21'd9, 1'b0),
      word_row(MODE_LOOKUP, 21'd9, 1'b0),
      word_row(MODE_LOOKUP, 21'd9, 1'b1),
      word_row(MODE_INSERT, 21'd5, 1'b0),
      word_row(MODE_LOOKUP, 21'd6, 1'b1),
      word_row(MODE_LOOKUP, 21'd1, 1'b0),
      word_row(MODE_INSERT, 21'd7, 1'b1),
      cap_row(13'd1),
      word_row(MODE_INSERT, 21'd200, 1'b0, 1, ST_FULL, NONE_IX),
      word_row(MODE_INSERT, 21'd201, 1'b0, 1, ST_FULL, NONE_IX),
      word_row(MODE_INSERT, 21'd202, 1'b1, 1, ST_FULL, NONE_IX),
      word_row(MODE_INSERT, 21'd1, 1'b1, 1, ST_PRESENT, 13'd0),
      word_row(MODE_LOOKUP, 21'd0, 1'b1),
      cap_row(CAP_RESET)
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CAP) begin
        wait_idle();
        write_cap(dir_tab[i].cap);
      end else begin
        send_char(dir_tab[i].mode, dir_tab[i].cp, dir_tab[i].last,
                  dir_tab[i].typed, dir_tab[i].res);
      end
    end

    sent = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: cap_v = CAP_RESET;
        1: cap_v = 13'd1;
        2: cap_v = CAP_W'(nodes_used + $urandom_range(0, 15));
        3: cap_v = CAP_W'($urandom_range(1, NODES));
        4: cap_v = nodes_used;
        default: cap_v = CAP_W'(nodes_used + $urandom_range(1, 60));
      endcase
      if (cap_v == 0) cap_v = 13'd1;
      if (cap_v > NODES) cap_v = CAP_RESET;
      write_cap(cap_v);
      for (int k = 0; k < 6; k++) begin
        if (k < 2) alpha[k] = edge_cps[$urandom_range(0, 4)];
        else if (k < 4) alpha[k] = CP_W'($urandom_range(1, 1114111));
        else alpha[k] = CP_W'($urandom_range('h60, 'h70));
      end
      target = (ph == 1) ? sent + 40 : (ph + 1) * RANDOM_ITEMS / PHASES;
      if (ph == PHASES - 1) target = RANDOM_ITEMS;
      while (sent < target) begin
        roll = $urandom_range(0, 99);
        mode_roll = $urandom_range(0, 99);
        mixed = 0;
        if (roll < 30 && inserted_words.size() != 0) begin
          w = inserted_words[$urandom_range(0, inserted_words.size() - 1)];
          m = (mode_roll < 70) ? MODE_LOOKUP : MODE_INSERT;
        end else if (mode_roll < 90) begin
          w.len = $urandom_range(1, 5);
          for (int k = 0; k < 6; k++) w.ch[k] = alpha[$urandom_range(0, 5)];
          m = (mode_roll < 45) ? MODE_INSERT : MODE_LOOKUP;
          mixed = (mode_roll >= 80);
        end else begin
          w.len = $urandom_range(1, 2);
          for (int k = 0; k < 6; k++) w.ch[k] = CP_W'($urandom_range(0, 1114111));
          m = 1'($urandom_range(0, 1));
        end
        if (m == MODE_INSERT && !mixed) begin
          inserted_words.insert(inserted_words.size(), w);
          if (inserted_words.size() > 256) void'(inserted_words.pop_front());
        end
        for (int k = 0; k < w.len; k++) begin
          send_char(mixed ? logic'($urandom_range(0, 1)) : m, w.ch[k],
                    k == w.len - 1, 0, none_res);
          sent++;
        end
        if (burst_left == 0 && $urandom_range(0, 19) == 0)
          burst_left = $urandom_range(8, 40);
        if ($urandom_range(0, 49) == 0) wait_idle();
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (word_q.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", word_q.size()));
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/tst_pkg.sv
hw/rtl/tst_ctrl.sv
hw/rtl/tst_dp.sv
hw/rtl/ternary_search_tree_insert_lookup_top.sv
tb/tb_top.sv
